/* rtl/per_class_greedy_nms_top_assert.svh */
// assertion macros for the per-class nms block
// used by per_class_greedy_nms_top, needs i_clk and i_rst_n in scope
`ifndef PER_CLASS_GREEDY_NMS_TOP_ASSERT_SVH
`define PER_CLASS_GREEDY_NMS_TOP_ASSERT_SVH

// same-cycle implication
`define PCNMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcnms assertion failed");

// next-cycle implication
`define PCNMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcnms assertion failed");

`endif

/* rtl/pcnms_pkg.sv */
// shared types and constants for the per-class nms block
// no dependencies
package pcnms_pkg;

    localparam int MAX_CAND = 64;
    localparam int IDX_W    = $clog2(MAX_CAND);
    localparam int CNT_W    = $clog2(MAX_CAND + 1);

    localparam logic [1:0] REG_SCORE_THR = 2'd0;
    localparam logic [1:0] REG_IOU_THR   = 2'd1;
    localparam logic [1:0] REG_CLASS_LIM = 2'd2;
    localparam logic [1:0] REG_MAX_KEPT  = 2'd3;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] top;
        logic [15:0] left;
        logic [15:0] bottom;
        logic [15:0] right;
    } t_cand;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_ROTATE,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] tail;
        t_cand            cand;
    } t_cell_ctl;

    typedef struct packed {
        logic [7:0]  out_class;
        logic [15:0] out_score;
        logic [15:0] out_top;
        logic [15:0] out_left;
        logic [15:0] out_height;
        logic [15:0] out_width;
        logic        run_last;
        logic        store_overflowed;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_ISSUE,
        ST_WAIT,
        ST_FLUSH
    } t_state;

endpackage

/* rtl/pcnms_if.sv */
// input and output channel interfaces of the per-class nms block
// depends on nothing but fixed field widths
interface pcnms_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  class_id;
    logic [15:0] score;
    logic [15:0] box_top;
    logic [15:0] box_left;
    logic [15:0] box_bottom;
    logic [15:0] box_right;
    logic        last_in_class;
    logic        last_in_frame;

    modport source (output valid, class_id, score, box_top, box_left, box_bottom,
                    box_right, last_in_class, last_in_frame, input ready);
    modport sink (input valid, class_id, score, box_top, box_left, box_bottom,
                  box_right, last_in_class, last_in_frame, output ready);
endinterface

interface pcnms_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_class;
    logic [15:0] out_score;
    logic [15:0] out_top;
    logic [15:0] out_left;
    logic [15:0] out_height;
    logic [15:0] out_width;
    logic        run_last;
    logic        store_overflowed;

    modport source (output valid, out_class, out_score, out_top, out_left, out_height,
                    out_width, run_last, store_overflowed, input ready);
    modport sink (input valid, out_class, out_score, out_top, out_left, out_height,
                  out_width, run_last, store_overflowed, output ready);
endinterface

/* rtl/pcnms_cell.sv */
// one candidate cell of the sorted store
// depends on pcnms_pkg
module pcnms_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pcnms_pkg::IDX_W-1:0] i_idx,
    input  pcnms_pkg::t_cell_ctl      i_ctl,
    input  pcnms_pkg::t_cand          i_prev,
    input  logic                      i_prev_valid,
    input  logic                      i_prev_shift,
    input  pcnms_pkg::t_cand          i_next,
    input  logic                      i_next_valid,
    input  pcnms_pkg::t_cand          i_head,
    output pcnms_pkg::t_cand          o_cand,
    output logic                      o_valid,
    output logic                      o_shift
);
    import pcnms_pkg::*;

    t_cand r_cand, n_cand;
    logic  r_valid, n_valid;

    assign o_shift = r_valid && (r_cand.score < i_ctl.cand.score);
    assign o_cand  = r_cand;
    assign o_valid = r_valid;

    always_comb begin
        n_cand  = r_cand;
        n_valid = r_valid;
        case (i_ctl.op)
            OP_INSERT: begin
                if (i_prev_shift) begin
                    n_cand  = i_prev;
                    n_valid = 1'b1;
                end else if ((!r_valid || o_shift) && i_prev_valid) begin
                    n_cand  = i_ctl.cand;
                    n_valid = 1'b1;
                end
            end
            OP_SHIFT: begin
                n_cand  = i_next;
                n_valid = i_next_valid;
            end
            OP_ROTATE: begin
                if (i_idx < i_ctl.tail) begin
                    n_cand = i_next;
                end else if (i_idx == i_ctl.tail) begin
                    n_cand = i_head;
                end
            end
            OP_CLEAR: n_valid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end
endmodule

/* rtl/pcnms_chain.sv */
// row of candidate cells kept in descending score order
// depends on pcnms_pkg and pcnms_cell
module pcnms_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcnms_pkg::t_cell_ctl i_ctl,
    output pcnms_pkg::t_cand     o_head
);
    import pcnms_pkg::*;

    t_cand w_cand  [MAX_CAND];
    logic  w_valid [MAX_CAND];
    logic  w_shift [MAX_CAND];
    t_cand w_prev  [MAX_CAND];
    logic  w_prev_valid [MAX_CAND];
    logic  w_prev_shift [MAX_CAND];
    t_cand w_next  [MAX_CAND];
    logic  w_next_valid [MAX_CAND];

    always_comb begin
        for (int k = 0; k < MAX_CAND; k++) begin
            if (k == 0) begin
                w_prev[k]       = i_ctl.cand;
                w_prev_valid[k] = 1'b1;
                w_prev_shift[k] = 1'b0;
            end else begin
                w_prev[k]       = w_cand[k-1];
                w_prev_valid[k] = w_valid[k-1];
                w_prev_shift[k] = w_shift[k-1];
            end
            if (k == MAX_CAND - 1) begin
                w_next[k]       = w_cand[k];
                w_next_valid[k] = 1'b0;
            end else begin
                w_next[k]       = w_cand[k+1];
                w_next_valid[k] = w_valid[k+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_CAND; g++) begin : g_cell
        pcnms_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (IDX_W'(g)),
            .i_ctl        (i_ctl),
            .i_prev       (w_prev[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_prev_shift (w_prev_shift[g]),
            .i_next       (w_next[g]),
            .i_next_valid (w_next_valid[g]),
            .i_head       (w_cand[0]),
            .o_cand       (w_cand[g]),
            .o_valid      (w_valid[g]),
            .o_shift      (w_shift[g])
        );
    end

    assign o_head = w_cand[0];
endmodule

/* rtl/pcnms_iou.sv */
// pipelined iou overlap test of one candidate against the probe box
// depends on pcnms_pkg
module pcnms_iou (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_start,
    input  pcnms_pkg::t_cand i_cand,
    input  logic [15:0]      i_iou_thr,
    output logic             o_done,
    output logic             o_sup
);
    import pcnms_pkg::*;

    logic [15:0] r_pl, r_pt, r_pr, r_pb;
    logic [31:0] r_parea;
    logic [15:0] r_iw, r_ih, r_cw, r_ch;
    logic [31:0] r_inter2, r_carea;
    logic [31:0] r_inter3;
    logic [32:0] r_uni;
    logic [31:0] r_inter4;
    logic [31:0] r_plo;
    logic [32:0] r_phi;
    logic        r_sup;
    logic [4:0]  r_vld;

    logic [15:0] w_il, w_it, w_ir, w_ib;
    logic [48:0] w_lhs, w_rhs;

    assign w_il = (r_pl > i_cand.left)   ? r_pl : i_cand.left;
    assign w_it = (r_pt > i_cand.top)    ? r_pt : i_cand.top;
    assign w_ir = (r_pr < i_cand.right)  ? r_pr : i_cand.right;
    assign w_ib = (r_pb < i_cand.bottom) ? r_pb : i_cand.bottom;
    assign w_lhs = {1'b0, r_inter4, 16'd0};
    assign w_rhs = {r_phi, 16'd0} + {17'd0, r_plo};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pl    <= i_cand.left;
            r_pt    <= i_cand.top;
            r_pr    <= i_cand.right;
            r_pb    <= i_cand.bottom;
            r_parea <= 32'(i_cand.right - i_cand.left) * 32'(i_cand.bottom - i_cand.top);
        end
        r_iw     <= (w_ir > w_il) ? w_ir - w_il : 16'd0;
        r_ih     <= (w_ib > w_it) ? w_ib - w_it : 16'd0;
        r_cw     <= i_cand.right - i_cand.left;
        r_ch     <= i_cand.bottom - i_cand.top;
        r_inter2 <= 32'(r_iw) * 32'(r_ih);
        r_carea  <= 32'(r_cw) * 32'(r_ch);
        r_inter3 <= r_inter2;
        r_uni    <= {1'b0, r_parea} + {1'b0, r_carea} - {1'b0, r_inter2};
        r_inter4 <= r_inter3;
        r_plo    <= 32'(i_iou_thr) * 32'(r_uni[15:0]);
        r_phi    <= 33'(i_iou_thr) * 33'(r_uni[32:16]);
        r_sup    <= w_lhs > w_rhs;
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    assign o_done = r_vld[4];
    assign o_sup  = r_sup;
endmodule

/* rtl/per_class_greedy_nms_top.sv */
// top level of the per-class greedy nms block: control sequencer and output register
// depends on pcnms_pkg, pcnms_if, pcnms_chain, pcnms_iou and the assertion header
//
// Boxes enter a row of 64 cells kept in descending score order, one item per cycle while idle.
// An item that closes a class run starts the suppression pass, during which no
// item is taken: each surviving box takes a pick step and a final issue step, and
// every candidate still behind it passes the shared iou unit (an issue step and five
// pipeline stages); a stalled output holds the pick and the flush that closes the run.
// Results leave through an output register with valid/ready.
module per_class_greedy_nms_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pcnms_in_if.sink    i_in,
    pcnms_out_if.source o_out
);
    import pcnms_pkg::*;

    `include "per_class_greedy_nms_top_assert.svh"

    logic [15:0] r_score_thr, r_iou_thr;
    logic [7:0]  r_class_lim;
    logic [9:0]  r_max_kept;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic [9:0]       r_kept, n_kept;
    logic             r_ff, n_ff;
    logic             r_ovf, n_ovf;
    logic             r_lf, n_lf;
    logic [7:0]       r_cls, n_cls;
    t_res             r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_res             r_out, n_out;
    logic             r_out_v, n_out_v;

    t_cell_ctl w_ctl;
    t_cand     w_head;
    t_cand     w_in;
    logic      w_load, w_start, w_done, w_sup;
    logic      w_out_free, w_ff_in, w_take;
    logic [9:0] w_kept_inc;

    assign w_in.score  = i_in.score;
    assign w_in.top    = i_in.box_top;
    assign w_in.left   = i_in.box_left;
    assign w_in.bottom = i_in.box_bottom;
    assign w_in.right  = i_in.box_right;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_out_free = !r_out_v || o_out.ready;
    assign w_ff_in    = r_ff || (r_kept >= r_max_kept);
    assign w_take     = !w_ff_in && (i_in.score >= r_score_thr)
                        && (i_in.box_bottom > i_in.box_top) && (i_in.box_right > i_in.box_left)
                        && ((r_class_lim == 8'd0) || (i_in.class_id < r_class_lim));
    assign w_kept_inc = r_kept + 10'd1;

    pcnms_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    pcnms_iou u_iou (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_start   (w_start),
        .i_cand    (w_head),
        .i_iou_thr (r_iou_thr),
        .o_done    (w_done),
        .o_sup     (w_sup)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_scan   = r_scan;
        n_kept   = r_kept;
        n_ff     = r_ff;
        n_ovf    = r_ovf;
        n_lf     = r_lf;
        n_cls    = r_cls;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !o_out.ready;
        w_ctl.op   = OP_HOLD;
        w_ctl.tail = '0;
        w_ctl.cand = w_in;
        w_load  = 1'b0;
        w_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_ff  = w_ff_in;
                    n_cls = i_in.class_id;
                    n_lf  = i_in.last_in_frame;
                    if (w_take) begin
                        w_ctl.op = OP_INSERT;
                        if (r_count == CNT_W'(MAX_CAND)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    if (i_in.last_in_class || i_in.last_in_frame) begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                if (r_ff || (r_count == '0)) begin
                    n_state = ST_FLUSH;
                end else if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_out_v = 1'b1;
                    end
                    n_pend.out_class        = r_cls;
                    n_pend.out_score        = w_head.score;
                    n_pend.out_top          = w_head.top;
                    n_pend.out_left         = w_head.left;
                    n_pend.out_height       = w_head.bottom - w_head.top;
                    n_pend.out_width        = w_head.right - w_head.left;
                    n_pend.run_last         = 1'b0;
                    n_pend.store_overflowed = r_ovf;
                    n_pend_v = 1'b1;
                    w_load   = 1'b1;
                    w_ctl.op = OP_SHIFT;
                    n_count  = r_count - 1'b1;
                    n_scan   = r_count - 1'b1;
                    n_kept   = w_kept_inc;
                    if (w_kept_inc >= r_max_kept) begin
                        n_ff = 1'b1;
                    end
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_scan == '0) begin
                    n_state = ST_PICK;
                end else begin
                    w_start = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    if (w_sup) begin
                        w_ctl.op = OP_SHIFT;
                        n_count  = r_count - 1'b1;
                    end else begin
                        w_ctl.op   = OP_ROTATE;
                        w_ctl.tail = IDX_W'(r_count - 1'b1);
                    end
                    n_scan  = r_scan - 1'b1;
                    n_state = ST_ISSUE;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v) begin
                    if (w_out_free) begin
                        n_out          = r_pend;
                        n_out.run_last = 1'b1;
                        n_out_v        = 1'b1;
                        n_pend_v       = 1'b0;
                    end
                end else begin
                    w_ctl.op = OP_CLEAR;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    if (r_lf) begin
                        n_kept = '0;
                        n_ff   = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        r_cls  <= n_cls;
        r_scan <= n_scan;
        r_lf   <= n_lf;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_kept      <= '0;
            r_ff        <= 1'b0;
            r_ovf       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_score_thr <= 16'd0;
            r_iou_thr   <= 16'd32768;
            r_class_lim <= 8'd0;
            r_max_kept  <= 10'd200;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_kept   <= n_kept;
            r_ff     <= n_ff;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCORE_THR: r_score_thr <= i_cfg_data;
                    REG_IOU_THR:   r_iou_thr   <= i_cfg_data;
                    REG_CLASS_LIM: r_class_lim <= i_cfg_data[7:0];
                    REG_MAX_KEPT:  r_max_kept  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid            = r_out_v;
    assign o_out.out_class        = r_out.out_class;
    assign o_out.out_score        = r_out.out_score;
    assign o_out.out_top          = r_out.out_top;
    assign o_out.out_left         = r_out.out_left;
    assign o_out.out_height       = r_out.out_height;
    assign o_out.out_width        = r_out.out_width;
    assign o_out.run_last         = r_out.run_last;
    assign o_out.store_overflowed = r_out.store_overflowed;

    `PCNMS_ASSERT_NEXT(a_run_starts_pass,
        i_in.valid && i_in.ready && (i_in.last_in_class || i_in.last_in_frame),
        r_state == ST_PICK)
    `PCNMS_ASSERT_NOW(a_iou_done_in_wait, w_done, r_state == ST_WAIT)
    `PCNMS_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= CNT_W'(MAX_CAND))
    `PCNMS_ASSERT_NEXT(a_flush_clears, (r_state == ST_FLUSH) && !r_pend_v,
        (r_count == '0) && !r_ovf && (r_state == ST_IDLE))
endmodule

/* bench/tb_top.sv */
// self-checking bench for per_class_greedy_nms_top: directed table and cases, then random frames
// predicts kept boxes with its own ordered store and iou test; needs pcnms_pkg and pcnms_if
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcnms_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE       = 15000;
    localparam int DEPTH        = MAX_CAND;

    typedef struct {
        logic [7:0]  class_id;
        logic [15:0] score, top, left, bottom, right;
        logic        lc, lf;
    } t_box_item;

    typedef struct {
        t_box_item item;
        bit        typed;
        int        n_typed;
        t_res      res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    pcnms_in_if  in_ch();
    pcnms_out_if out_ch();

    per_class_greedy_nms_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch), .o_out(out_ch)
    );

    // predictor state
    logic [15:0] score_thr, iou_thr;
    logic [7:0]  class_lim;
    logic [9:0]  kept_limit;
    t_cand       cands [DEPTH];
    int          cand_cnt;
    bit          kept_mark [DEPTH];
    logic [9:0]  kept_total;
    bit          overflowed, frame_full;

    t_res        expected_boxes [$];
    int          errors;
    int          cycles;
    int          send_idle_pct, recv_idle_pct;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit overlap_too_big(t_cand a, t_cand b);
        logic [63:0] il, it, ir, ib, iw, ih, inter, area_a, area_b, uni;
        il = (a.left > b.left) ? a.left : b.left;
        it = (a.top > b.top) ? a.top : b.top;
        ir = (a.right < b.right) ? a.right : b.right;
        ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        iw = (ir > il) ? ir - il : 64'd0;
        ih = (ib > it) ? ib - it : 64'd0;
        inter = iw * ih;
        area_a = 64'(a.right - a.left) * 64'(a.bottom - a.top);
        area_b = 64'(b.right - b.left) * 64'(b.bottom - b.top);
        uni = area_a + area_b - inter;
        return (inter * 64'd65536) > (64'(iou_thr) * uni);
    endfunction

    task automatic store_candidate(t_cand c);
        int pos;
        pos = cand_cnt;
        while (pos > 0 && cands[pos-1].score < c.score) pos--;
        if (cand_cnt >= DEPTH) begin
            overflowed = 1'b1;
            if (pos >= DEPTH) return;
            for (int k = DEPTH - 1; k > pos; k--) cands[k] = cands[k-1];
            cands[pos] = c;
        end else begin
            for (int k = cand_cnt; k > pos; k--) cands[k] = cands[k-1];
            cands[pos] = c;
            cand_cnt++;
        end
    endtask

    // returns the kept boxes this transaction causes
    task automatic predict_nms(t_box_item it, output t_res kept [$]);
        t_cand c;
        t_res  r;
        bit    keep;
        kept = {};
        c.score = it.score; c.top = it.top; c.left = it.left;
        c.bottom = it.bottom; c.right = it.right;
        if (kept_total >= kept_limit) frame_full = 1'b1;
        if (!frame_full && it.score >= score_thr && it.bottom > it.top &&
            it.right > it.left && (class_lim == 0 || it.class_id < class_lim))
            store_candidate(c);
        if (it.lc || it.lf) begin
            for (int i = 0; i < cand_cnt; i++) begin
                if (frame_full) break;
                keep = 1'b1;
                for (int j = 0; j < i; j++)
                    if (kept_mark[j] && overlap_too_big(cands[j], cands[i])) begin
                        keep = 1'b0;
                        break;
                    end
                if (!keep) continue;
                kept_mark[i] = 1'b1;
                r.out_class = it.class_id;
                r.out_score = cands[i].score;
                r.out_top = cands[i].top;
                r.out_left = cands[i].left;
                r.out_height = cands[i].bottom - cands[i].top;
                r.out_width = cands[i].right - cands[i].left;
                r.run_last = 1'b0;
                r.store_overflowed = overflowed;
                kept.push_back(r);
                kept_total = kept_total + 10'd1;
                if (kept_total >= kept_limit) frame_full = 1'b1;
            end
            if (kept.size() > 0) kept[kept.size()-1].run_last = 1'b1;
            cand_cnt = 0;
            foreach (kept_mark[k]) kept_mark[k] = 1'b0;
            overflowed = 1'b0;
        end
        if (it.lf) begin
            kept_total = '0;
            frame_full = 1'b0;
        end
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // output monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_boxes.size() == 0) begin
                $error("unexpected output transaction, class %0h", out_ch.out_class);
                errors++;
            end else begin
                e = expected_boxes.pop_front();
                check_field("out_class", e.out_class, out_ch.out_class);
                check_field("out_score", e.out_score, out_ch.out_score);
                check_field("out_top", e.out_top, out_ch.out_top);
                check_field("out_left", e.out_left, out_ch.out_left);
                check_field("out_height", e.out_height, out_ch.out_height);
                check_field("out_width", e.out_width, out_ch.out_width);
                check_field("run_last", e.run_last, out_ch.run_last);
                check_field("store_overflowed", e.store_overflowed,
                            out_ch.store_overflowed);
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCORE_THR: score_thr = val;
            REG_IOU_THR:   iou_thr = val;
            REG_CLASS_LIM: class_lim = val[7:0];
            REG_MAX_KEPT:  kept_limit = val[9:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sends one transaction; typed rows replace the predicted results
    task automatic send_box(t_box_item it, bit typed = 0, int n_typed = 0,
                            t_res typed_res = '0);
        t_res kept [$];
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.class_id <= it.class_id;
        in_ch.score <= it.score;
        in_ch.box_top <= it.top;
        in_ch.box_left <= it.left;
        in_ch.box_bottom <= it.bottom;
        in_ch.box_right <= it.right;
        in_ch.last_in_class <= it.lc;
        in_ch.last_in_frame <= it.lf;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_nms(it, kept);
        if (typed) begin
            if (n_typed > 0) expected_boxes.push_back(typed_res);
        end else begin
            foreach (kept[k]) expected_boxes.push_back(kept[k]);
        end
    endtask

    function automatic t_box_item make_box(logic [7:0] cls, int cy, int cx, int spread,
                                           bit lc, bit lf);
        t_box_item b;
        int h, w;
        b.class_id = cls;
        b.score = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom);
        h = $urandom_range(16, 2000);
        w = $urandom_range(16, 2000);
        b.top = 16'(cy + $urandom_range(0, spread));
        b.left = 16'(cx + $urandom_range(0, spread));
        b.bottom = 16'(b.top + h);
        b.right = 16'(b.left + w);
        b.lc = lc;
        b.lf = lf;
        return b;
    endfunction

    function automatic t_box_item noise_box();
        t_box_item b;
        b.class_id = 8'($urandom);
        b.score = 16'($urandom);
        b.top = 16'($urandom);
        b.left = 16'($urandom);
        b.bottom = 16'($urandom);
        b.right = 16'($urandom);
        b.lc = 1'($urandom_range(0, 1));
        b.lf = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    task automatic random_frames(int quota);
        int sent, len, cy, cx, spread;
        logic [7:0] cls;
        bit lc;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 9) == 0) begin
                send_box(noise_box());
                sent++;
                continue;
            end
            cls = (class_lim != 0 && $urandom_range(0, 4) != 0) ?
                  8'($urandom_range(0, class_lim - 1)) : 8'($urandom);
            len = $urandom_range(1, 8);
            cy = $urandom_range(0, 60000);
            cx = $urandom_range(0, 60000);
            spread = $urandom_range(0, 1) ? 200 : 3000;
            for (int k = 0; k < len; k++) begin
                lc = (k == len - 1) && ($urandom_range(0, 9) != 0);
                send_box(make_box(cls, cy, cx, spread, lc,
                                  (k == len - 1) && ($urandom_range(0, 4) == 0)));
                sent++;
            end
        end
    endtask

    task automatic random_config();
        write_reg(REG_SCORE_THR, ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0000);
        write_reg(REG_IOU_THR, 16'($urandom));
        write_reg(REG_CLASS_LIM, $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'd0);
        write_reg(REG_MAX_KEPT, $urandom_range(0, 3) == 0 ?
                  16'($urandom_range(1, 6)) : 16'($urandom_range(7, 1023)));
    endtask

    t_row      rows [$];
    t_row      row;
    t_box_item b;

    initial begin
        cycles = 0;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_we = 1'b0;
        cfg_idx = REG_SCORE_THR;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.class_id = '0;
        in_ch.score = '0;
        in_ch.box_top = '0;
        in_ch.box_left = '0;
        in_ch.box_bottom = '0;
        in_ch.box_right = '0;
        in_ch.last_in_class = 1'b0;
        in_ch.last_in_frame = 1'b0;
        out_ch.ready = 1'b0;
        score_thr = 16'd0;
        iou_thr = 16'd32768;
        class_lim = 8'd0;
        kept_limit = 10'd200;
        cand_cnt = 0;
        foreach (kept_mark[k]) kept_mark[k] = 1'b0;
        kept_total = '0;
        overflowed = 1'b0;
        frame_full = 1'b0;

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full-frame box at max score, reset settings
        row = '{item: '{8'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1, 0},
                typed: 1, n_typed: 1,
                res: '{8'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}};
        rows.push_back(row);
        // zero-size box dropped, marker still closes an empty run
        row = '{item: '{8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1, 0},
                typed: 1, n_typed: 0, res: '0};
        rows.push_back(row);
        // flat box dropped, then overlapping boxes with equal and ordered scores
        row = '{item: '{8'h05, 16'h1000, 16'h0100, 16'h0100, 16'h0100, 16'h0200, 0, 0},
                typed: 0, n_typed: 0, res: '0};
        rows.push_back(row);
        row.item = '{8'h05, 16'h4000, 16'h0100, 16'h0100, 16'h0300, 16'h0300, 0, 0};
        rows.push_back(row);
        row.item = '{8'h05, 16'h4000, 16'h0110, 16'h0110, 16'h0310, 16'h0310, 0, 0};
        rows.push_back(row);
        row.item = '{8'h05, 16'h9000, 16'h0800, 16'h0800, 16'h0900, 16'h0900, 0, 0};
        rows.push_back(row);
        row.item = '{8'h05, 16'h2000, 16'h0120, 16'h0100, 16'h0320, 16'h0300, 1, 0};
        rows.push_back(row);
        // frame end closes an open run
        row.item = '{8'h07, 16'h7FFF, 16'h1000, 16'h2000, 16'h1400, 16'h2400, 0, 0};
        rows.push_back(row);
        row.item = '{8'h07, 16'h8000, 16'h1010, 16'h2010, 16'h1410, 16'h2410, 0, 1};
        rows.push_back(row);
        // disjoint boxes and touching edges
        row.item = '{8'h80, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 0, 0};
        rows.push_back(row);
        row.item = '{8'h80, 16'h0002, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 1, 1};
        rows.push_back(row);
        foreach (rows[r]) send_box(rows[r].item, rows[r].typed, rows[r].n_typed, rows[r].res);
        wait_idle();

        // threshold extremes and class limit
        write_reg(REG_SCORE_THR, 16'hFFFF);
        write_reg(REG_CLASS_LIM, 16'd255);
        write_reg(REG_IOU_THR, 16'd0);
        send_box('{8'hFE, 16'hFFFF, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 0, 0});
        send_box('{8'hFF, 16'hFFFF, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 0, 0});
        send_box('{8'h01, 16'hFFFE, 16'h0010, 16'h0010, 16'h0020, 16'h0020, 0, 0});
        send_box('{8'hFE, 16'hFFFF, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 1, 1});
        wait_idle();

        // kept limit reached mid run and frame ends
        write_reg(REG_SCORE_THR, 16'h0000);
        write_reg(REG_CLASS_LIM, 16'd0);
        write_reg(REG_IOU_THR, 16'hFFFF);
        write_reg(REG_MAX_KEPT, 16'd1);
        for (int k = 0; k < 3; k++)
            send_box(make_box(8'h11, 1000 * k, 1000 * k, 0, k == 2, 1'b0));
        send_box(make_box(8'h12, 40000, 40000, 100, 1'b1, 1'b1));
        wait_idle();

        // store overflow in one class
        write_reg(REG_MAX_KEPT, 16'd1023);
        for (int k = 0; k < DEPTH + 4; k++) begin
            b = make_box(8'h09, (k % 8) * 7000, (k / 8) * 6000, 0, k == DEPTH + 3, 1'b0);
            send_box(b);
        end
        send_box('{8'h09, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1});
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 26 : (p == 1) ? 50 : 0;
            recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 26 : 0;
            for (int s = 0; s < 3; s++) begin
                random_config();
                random_frames(12);
                wait_idle();
            end
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
